// ===== design/lpp_pkg.sv =====
// Package for the longest palindromic prefix unit.
// Holds field widths; no dependencies.
`default_nettype none
package lpp_pkg;
  localparam int CharW = 8;
  localparam int LenW  = 11;
  localparam int PrepW = 10;
endpackage
`default_nettype wire

// ===== design/lpp_if.sv =====
// Valid/ready channel interfaces for the longest palindromic prefix unit.
// Depends on lpp_pkg for the field widths.
`default_nettype none
interface lpp_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpp_pkg::CharW-1:0]     char_value;
  logic                          last_char;
  modport source (output valid, output char_value, output last_char, input ready);
  modport sink   (input valid, input char_value, input last_char, output ready);
endinterface

interface lpp_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpp_pkg::LenW-1:0]      palindrome_prefix_len;
  logic [lpp_pkg::PrepW-1:0]     prepend_count;
  logic                          overflow;
  modport source (output valid, output palindrome_prefix_len, output prepend_count,
                  output overflow, input ready);
  modport sink   (input valid, input palindrome_prefix_len, input prepend_count,
                  input overflow, output ready);
endinterface
`default_nettype wire

// ===== design/lpp_mem.sv =====
// Synchronous single-write, dual-read memory with registered read data.
// No package dependency.
`default_nettype none
module lpp_mem #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr_a,
  input  wire logic [$clog2(Depth)-1:0] raddr_b,
  output logic      [Width-1:0]         rdata_a,
  output logic      [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== design/longest_palindromic_prefix_unit.sv =====
// Top level of the longest palindromic prefix unit.
// Depends on lpp_pkg, lpp_if and lpp_mem.
//
// Channel   Dir  Fields
// in        in   char_value[7:0], last_char
// out       out  palindrome_prefix_len[10:0], prepend_count[9:0], overflow
//
// Bytes without last_char are accepted back to back in the load state. After a last byte,
// each Z entry takes a start state, a fetch state when a mirrored Z value is reused and
// a compare state per character comparison; the right-to-left scan does the same per
// end position and stops at the first palindromic end.
// Reset is synchronous and active low and clears the control state only.
// The result waits in an output register while the next string loads; a finished
// computation stalls in S_DONE only while that register still holds an untaken result.
`default_nettype none
module longest_palindromic_prefix_unit #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lpp_in_if.sink    in_ch,
  lpp_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  // States of the sequencer, one-hot.
  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_ZINIT = 8'b0000_0010, // start entry i of the Z build
    S_ZFET  = 8'b0000_0100, // Z value of the mirror is on the read port
    S_ZCMP  = 8'b0000_1000, // two characters are on the read ports
    S_PINIT = 8'b0001_0000, // start end position i of the scan
    S_PFET  = 8'b0010_0000,
    S_PCMP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // loaded count
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] z_r, z_nxt;           // running match length (z or b)
  logic [CW-1:0] wl_r, wl_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [CW-1:0] fnd_r, fnd_nxt;       // prefix length found by the scan
  logic          res_v_r, res_v_nxt;
  logic [lpp_pkg::LenW-1:0]  res_len_r, res_len_nxt;
  logic [lpp_pkg::PrepW-1:0] res_prep_r, res_prep_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  // Memory ports.
  logic            c_we;
  logic [AW-1:0]   c_wa, c_ra, c_rb;
  logic [7:0]      c_wd, c_da, c_db;
  logic            z_we;
  logic [AW-1:0]   z_wa, z_ra;
  logic [CW-1:0]   z_wd, z_da, z_db;

  lpp_mem #(.Depth(MAX_LEN), .Width(8)) u_char (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .raddr_a(c_ra), .raddr_b(c_rb), .rdata_a(c_da), .rdata_b(c_db));

  lpp_mem #(.Depth(MAX_LEN), .Width(CW)) u_zval (
    .clk(clk), .we(z_we), .waddr(z_wa), .wdata(z_wd),
    .raddr_a(z_ra), .raddr_b(z_ra), .rdata_a(z_da), .rdata_b(z_db));

  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  // Bytes are taken only in the load state. While a string is computed the input
  // stalls; a result waiting in the output register does not hold back loading.
  assign in_ch.ready = (state_r == S_LOAD);

  assign out_ch.valid                 = res_v_r;
  assign out_ch.palindrome_prefix_len = res_len_r;
  assign out_ch.prepend_count         = res_prep_r;
  assign out_ch.overflow              = res_ovf_r;

  // Helper values, widened one bit for compares.
  logic [CW:0] iz, ip1, cap, span;
  assign iz   = {1'b0, i_r} + {1'b0, z_r};
  assign ip1  = {1'b0, i_r} + {{CW{1'b0}}, 1'b1};
  assign cap  = {1'b0, wr_r} - {1'b0, i_r};
  assign span = {1'b0, i_r} - {1'b0, wl_r} + {{CW{1'b0}}, 1'b1};

  // Next mismatch test of the Z build: continue while i+z<n and chars equal.
  logic z_more;
  assign z_more = (iz < {1'b0, cnt_r});
  // Scan extension continues while b<=i.
  logic p_more;
  assign p_more = ({1'b0, z_r} <= {1'b0, i_r});
  // The prefix ending at i is a palindrome once b reaches half its length, rounded down.
  logic p_hit;
  assign p_hit  = (z_r >= ip1[CW:1]);

  always_comb begin
    logic [CW:0] zmin;
    logic [CW:0] zsum;
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    z_nxt        = z_r;
    wl_nxt       = wl_r;
    wr_nxt       = wr_r;
    fnd_nxt      = fnd_r;
    res_v_nxt    = res_v_r && !out_acc;
    res_len_nxt  = res_len_r;
    res_prep_nxt = res_prep_r;
    res_ovf_nxt  = res_ovf_r;
    c_we = 1'b0; c_wa = cnt_r[AW-1:0]; c_wd = in_ch.char_value;
    c_ra = z_r[AW-1:0];
    c_rb = iz[AW-1:0];
    z_we = 1'b0; z_wa = i_r[AW-1:0]; z_wd = z_r;
    z_ra = '0;
    zmin = '0;
    zsum = '0;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if ({1'b0, cnt_r} < (CW+1)'(MAX_LEN)) begin
            c_we    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_char) begin
            // Z[0] = n.
            z_we = 1'b1;
            z_wa = '0;
            z_wd = ({1'b0, cnt_r} < (CW+1)'(MAX_LEN)) ? cnt_r + 1'b1 : cnt_r;
            i_nxt  = CW'(1);
            wl_nxt = '0;
            wr_nxt = '0;
            state_nxt = S_ZINIT;
          end
        end
      end
      S_ZINIT: begin
        if ({1'b0, i_r} >= {1'b0, cnt_r}) begin
          i_nxt  = cnt_r;
          wl_nxt = cnt_r;
          wr_nxt = cnt_r;
          state_nxt = S_PINIT;
        end else if (i_r < wr_r) begin
          z_ra = AW'(i_r - wl_r);
          state_nxt = S_ZFET;
        end else begin
          z_nxt = '0;
          c_ra  = '0;
          c_rb  = i_r[AW-1:0];
          state_nxt = S_ZCMP;
        end
      end
      S_ZFET: begin
        zmin  = ({1'b0, z_da} < cap) ? {1'b0, z_da} : cap;
        z_nxt = zmin[CW-1:0];
        zsum  = {1'b0, i_r} + zmin;
        c_ra  = zmin[AW-1:0];
        c_rb  = zsum[AW-1:0];
        state_nxt = S_ZCMP;
      end
      S_ZCMP: begin
        // Read data belongs to the current z; valid only while i+z<n.
        if (z_more && (c_da == c_db)) begin
          z_nxt = z_r + 1'b1;
          zsum  = iz + 1'b1;
          c_ra  = AW'(z_r + 1'b1);
          c_rb  = zsum[AW-1:0];
        end else begin
          z_we = 1'b1;
          if (iz > {1'b0, wr_r}) begin
            wl_nxt = i_r;
            wr_nxt = iz[CW-1:0];
          end
          i_nxt = i_r + 1'b1;
          state_nxt = S_ZINIT;
        end
      end
      S_PINIT: begin
        // i_r holds the end position plus one here.
        if (i_r == '0) begin
          fnd_nxt   = CW'(1);
          state_nxt = S_DONE;
        end else begin
          i_nxt = i_r - 1'b1;
          if ((i_r - 1'b1) < wl_r) begin
            z_nxt = '0;
            c_ra  = '0;
            c_rb  = AW'(i_r - 1'b1);
            state_nxt = S_PCMP;
          end else begin
            z_ra = AW'(wr_r - (i_r - 1'b1));
            state_nxt = S_PFET;
          end
        end
      end
      S_PFET: begin
        if ({1'b0, z_da} < span) begin
          z_nxt = z_da;
          if (z_da >= ip1[CW:1]) begin
            fnd_nxt   = ip1[CW-1:0];
            state_nxt = S_DONE;
          end else begin
            // Back to PINIT, which expects end+1.
            i_nxt = i_r;
            state_nxt = S_PINIT;
          end
        end else begin
          z_nxt = span[CW-1:0];
          c_ra  = span[AW-1:0];
          c_rb  = AW'({1'b0, i_r} - span);
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (p_more && (c_da == c_db)) begin
          z_nxt = z_r + 1'b1;
          c_ra  = AW'(z_r + 1'b1);
          c_rb  = AW'(i_r - z_r - 1'b1);
        end else begin
          wl_nxt = CW'(ip1 - {1'b0, z_r});
          wr_nxt = i_r;
          if (p_hit) begin
            fnd_nxt   = ip1[CW-1:0];
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PINIT;
          end
        end
      end
      S_DONE: begin
        // The output register is loaded only once the previous result is gone.
        if (!res_v_r || out_acc) begin
          res_v_nxt    = 1'b1;
          res_len_nxt  = lpp_pkg::LenW'(fnd_r);
          res_prep_nxt = lpp_pkg::PrepW'(cnt_r - fnd_r);
          res_ovf_nxt  = ovf_r;
          cnt_nxt      = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      wl_r    <= '0;
      wr_r    <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      wl_r    <= wl_nxt;
      wr_r    <= wr_nxt;
      res_v_r <= res_v_nxt;
    end
    i_r        <= i_nxt;
    z_r        <= z_nxt;
    fnd_r      <= fnd_nxt;
    res_len_r  <= res_len_nxt;
    res_prep_r <= res_prep_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  logic unused_zb;
  assign unused_zb = ^z_db;

`ifndef SYNTHESIS
  // A pending result must hold until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.palindrome_prefix_len))
    else $error("result changed while stalled");
  // The loaded count never exceeds the store depth.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= (CW+1)'(MAX_LEN))
    else $error("loaded count beyond store");
  // A reported prefix length is never zero.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_v_r) |-> res_len_r != '0)
    else $error("zero prefix length");
`endif
endmodule
`default_nettype wire

// ===== sim/lpp_tb_if.sv =====
// Testbench-side note: the channel interfaces come from design/lpp_if.sv.
// This file holds a small helper package for the palindrome test; it depends on lpp_pkg.
package lpp_tb_pkg;
  localparam int MaxStr = 1024;
  typedef struct packed {
    logic [lpp_pkg::LenW-1:0]  pal_len;
    logic [lpp_pkg::PrepW-1:0] prep;
    logic                      ovf;
  } pal_result_t;
endpackage

// ===== sim/longest_palindromic_prefix_unit_test.sv =====
// Self-checking test of longest_palindromic_prefix_unit: strings are streamed in,
// expected prefix lengths are computed by a direct palindrome search and compared.
// Depends on lpp_pkg, lpp_if, lpp_tb_pkg and the design.
module longest_palindromic_prefix_unit_test;
  logic clk;
  logic rst_n;
  lpp_in_if  in_ch();
  lpp_out_if out_ch();

  longest_palindromic_prefix_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("** longest_palindromic_prefix_unit: FAILED **");
    $finish;
  end

  // Predictor state: the bytes of the string being loaded.
  logic [lpp_pkg::CharW-1:0] str_bytes [lpp_tb_pkg::MaxStr];
  int                        str_count;
  bit                        str_dropped;
  lpp_tb_pkg::pal_result_t   expected_q[$];
  lpp_tb_pkg::pal_result_t   last_pred;
  int                        mismatches;
  bit                        calm;

  // Longest palindromic prefix by direct comparison of each candidate.
  function automatic int longest_prefix(int n);
    int  len;
    bit  ok;
    for (len = n; len > 1; len--) begin
      ok = 1;
      for (int k = 0; k < len / 2; k++)
        if (str_bytes[k] != str_bytes[len - 1 - k]) ok = 0;
      if (ok) return len;
    end
    return 1;
  endfunction

  // Updates the predictor for one accepted transaction.
  task automatic predict_char(logic [lpp_pkg::CharW-1:0] c, logic lst);
    lpp_tb_pkg::pal_result_t r;
    int                      p;
    if (str_count < lpp_tb_pkg::MaxStr) begin
      str_bytes[str_count] = c;
      str_count++;
    end else begin
      str_dropped = 1;
    end
    if (lst) begin
      p         = longest_prefix(str_count);
      r.pal_len = p[lpp_pkg::LenW-1:0];
      r.prep    = lpp_pkg::PrepW'(str_count - p);
      r.ovf     = str_dropped;
      expected_q = {expected_q, r};
      last_pred  = r;
      str_count   = 0;
      str_dropped = 0;
    end
  endtask

  // Sends one byte, with random idle bursts before it unless the run is calm.
  // Valid stays high after the transaction; the caller drops it when done.
  task automatic send_char(logic [lpp_pkg::CharW-1:0] c, logic lst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid      <= 1;
    in_ch.char_value <= c;
    in_ch.last_char  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_char(c, lst);
    @(negedge clk);
  endtask

  // Sends a whole string; mode picks random content, a palindromic prefix, or one with a bit flipped.
  task automatic send_string(int n, int mode, int alpha);
    logic [lpp_pkg::CharW-1:0] s [];
    int                        half;
    s = new[n];
    for (int k = 0; k < n; k++) s[k] = lpp_pkg::CharW'($urandom_range(0, alpha - 1));
    if (mode != 0) begin
      half = $urandom_range(1, n);
      for (int k = 0; k < half / 2; k++) s[half - 1 - k] = s[k];
      if (mode == 2)
        s[$urandom_range(0, n - 1)] ^= lpp_pkg::CharW'(1 << $urandom_range(0, 7));
    end
    for (int k = 0; k < n; k++) send_char(s[k], k == n - 1);
  endtask

  // Result checker with random stall bursts on the receiving side.
  initial begin
    lpp_tb_pkg::pal_result_t want;
    out_ch.ready = 0;
    mismatches   = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result len=%0d", out_ch.palindrome_prefix_len);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.palindrome_prefix_len !== want.pal_len || out_ch.prepend_count !== want.prep
              || out_ch.overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp len=%0d prep=%0d ovf=%0b got len=%0d prep=%0d ovf=%0b",
                       want.pal_len, want.prep, want.ovf, out_ch.palindrome_prefix_len,
                       out_ch.prepend_count, out_ch.overflow);
          end
        end
      end
    end
  end

  // Directed table: each row is one string given as a pattern. Where the answer
  // is obvious it is typed in; zero in exp_len means "use the predictor".
  typedef struct {
    int n;
    int pattern;   // 0 all 0x00, 1 all 0xFF, 2 abab.., 3 ramp, 4 racecar-like
    int exp_len;
  } dir_row_t;
  dir_row_t dir_rows[$] = '{
    '{1, 0, 1}, '{1, 1, 1}, '{2, 0, 2}, '{2, 3, 1}, '{5, 1, 5}, '{6, 2, 5},
    '{8, 3, 1}, '{7, 4, 0}, '{9, 4, 0}, '{64, 0, 64}, '{40, 1, 40},
    '{33, 3, 0}, '{3, 2, 3}, '{4, 2, 3}
  };

  initial begin
    logic [lpp_pkg::CharW-1:0] c;
    calm = 0;
    str_count = 0; str_dropped = 0;
    rst_n = 0;
    in_ch.valid = 0; in_ch.char_value = 0; in_ch.last_char = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].n; k++) begin
        case (dir_rows[r].pattern)
          0: c = 8'h00;
          1: c = 8'hFF;
          2: c = (k % 2) ? 8'h5A : 8'hA5;
          3: c = lpp_pkg::CharW'(k);
          default: c = lpp_pkg::CharW'(8'h30 + ((k < dir_rows[r].n / 2) ? k :
                                                dir_rows[r].n - 1 - k));
        endcase
        send_char(c, k == dir_rows[r].n - 1);
      end
      if (dir_rows[r].exp_len != 0 && int'(last_pred.pal_len) != dir_rows[r].exp_len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predicted %0d, table says %0d", r,
                   last_pred.pal_len, dir_rows[r].exp_len);
      end
    end
    in_ch.valid <= 0;
    // Sender pause: let every pending result drain.
    while (expected_q.size() != 0) @(negedge clk);
    // Random strings of one to eight bytes, most built to have long palindromic prefixes.
    for (int t = 0; t < 48; t++) begin
      if (t == 40) calm = 1;
      send_string($urandom_range(1, 8), $urandom_range(0, 2),
                  ($urandom_range(0, 1) != 0) ? 2 : 256);
    end
    in_ch.valid <= 0;
    repeat (400) begin
      if (expected_q.size() == 0) break;
      @(negedge clk);
    end
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("** longest_palindromic_prefix_unit: PASSED **");
    end else begin
      $display("** longest_palindromic_prefix_unit: FAILED **");
    end
    $finish;
  end
endmodule
